// ===== sv/nv21rm_pkg.sv =====
// Shared types, widths and helpers for the NV21 chroma reorder / mirror unit.
// No dependencies.
package nv21rm_pkg;

  localparam int PIX_W      = 8;
  localparam int DIM_W      = 13;
  localparam int CNT_W      = 12;
  localparam int ADDR_W     = 25;
  localparam int CFG_IDX_W  = 2;
  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  localparam logic [DIM_W-1:0] MAX_W_EVEN = DIM_W'(MAX_WIDTH - (MAX_WIDTH % 2));
  localparam logic [DIM_W-1:0] MAX_H_EVEN = DIM_W'(MAX_HEIGHT - (MAX_HEIGHT % 2));
  localparam logic [DIM_W-1:0] MIN_DIM    = DIM_W'(2);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH   = 2'd0,
    REG_FRAME_HEIGHT  = 2'd1,
    REG_PLANAR_OUT    = 2'd2,
    REG_MIRROR_ENABLE = 2'd3
  } cfg_reg_t;

  // Scan position of one request, captured as it is accepted
  typedef struct packed {
    logic              chroma;
    logic [CNT_W-1:0]  col;
    logic [CNT_W-1:0]  row;
    logic [ADDR_W-1:0] row_base;
    logic              last;
  } scan_t;

  // Clear bit 0 and clamp to 2..maxv
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                               input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] e;
    e = {v[DIM_W-1:1], 1'b0};
    if (e < MIN_DIM) begin
      e = MIN_DIM;
    end
    if (e > maxv) begin
      e = maxv;
    end
    return e;
  endfunction

endpackage

// ===== sv/nv21rm_if.sv =====
// Channel interfaces: source byte stream in, addressed byte stream out.
// Depends on nv21rm_pkg.
interface nv21rm_in_if import nv21rm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

interface nv21rm_out_if import nv21rm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] dest_address;
  logic [PIX_W-1:0]  pixel_out;
  logic              frame_end;

  modport source (output valid, output dest_address, output pixel_out, output frame_end,
                  input ready);
  modport sink   (input valid, input dest_address, input pixel_out, input frame_end,
                  output ready);
endinterface

// ===== sv/nv21rm_scan.sv =====
// Raster scan counters: column, row, plane and running row base address.
// Depends on nv21rm_pkg.
module nv21rm_scan import nv21rm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [DIM_W-1:0]  w,
  input  logic [DIM_W-1:0]  h,
  input  logic [ADDR_W-1:0] ylen,
  output scan_t             cur
);

  logic [CNT_W-1:0]  col_r, col_nxt;
  logic [CNT_W-1:0]  row_r, row_nxt;
  logic              chroma_r, chroma_nxt;
  logic [ADDR_W-1:0] base_r, base_nxt;

  logic [DIM_W-1:0] rows;
  logic [DIM_W-1:0] col_inc;
  logic [DIM_W-1:0] row_inc;
  logic             row_end;
  logic             plane_end;

  always_comb begin
    rows      = chroma_r ? {1'b0, h[DIM_W-1:1]} : h;
    col_inc   = {1'b0, col_r} + DIM_W'(1);
    row_inc   = {1'b0, row_r} + DIM_W'(1);
    row_end   = col_inc >= w;
    plane_end = row_inc >= rows;

    cur.chroma   = chroma_r;
    cur.col      = col_r;
    cur.row      = row_r;
    cur.row_base = base_r;
    cur.last     = row_end && plane_end && chroma_r;
  end

  always_comb begin
    col_nxt    = col_r;
    row_nxt    = row_r;
    chroma_nxt = chroma_r;
    base_nxt   = base_r;
    if (accept) begin
      if (row_end) begin
        col_nxt = '0;
        if (plane_end) begin
          row_nxt    = '0;
          chroma_nxt = !chroma_r;
          base_nxt   = chroma_r ? '0 : ylen;
        end else begin
          row_nxt  = row_inc[CNT_W-1:0];
          base_nxt = base_r + ADDR_W'(w);
        end
      end else begin
        col_nxt = col_inc[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      chroma_r <= 1'b0;
      base_r   <= '0;
    end else begin
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      chroma_r <= chroma_nxt;
      base_r   <= base_nxt;
    end
  end

endmodule

// ===== sv/nv21rm_addr.sv =====
// Destination address datapath: mirror, pair swap and planar split, two stages.
// Depends on nv21rm_pkg.
module nv21rm_addr import nv21rm_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  scan_t             s,
  input  logic [DIM_W-1:0]  w,
  input  logic [ADDR_W-1:0] ylen,
  input  logic              mirror,
  input  logic              planar,
  output logic [ADDR_W-1:0] addr
);

  localparam int HW_W   = DIM_W - 1;
  localparam int PROD_W = CNT_W + HW_W;

  logic [HW_W-1:0]   half_w;
  logic [ADDR_W-1:0] luma_col;
  logic [ADDR_W-1:0] kd;
  logic [ADDR_W-1:0] luma_sum;
  logic [ADDR_W-1:0] semi_sum;
  logic [PROD_W-1:0] prod;

  logic [ADDR_W-1:0] base_r;
  logic [PROD_W-1:0] prod_r;
  logic [ADDR_W-1:0] kd_r;
  logic              use_planar_r;
  logic              second_r;
  logic [ADDR_W-1:0] addr_r;

  logic [ADDR_W-1:0] plane;
  logic [ADDR_W-1:0] planar_sum;

  // first stage: column / pair index after mirroring, row product
  always_comb begin
    half_w   = w[DIM_W-1:1];
    luma_col = mirror ? (ADDR_W'(w) - ADDR_W'(1) - ADDR_W'(s.col)) : ADDR_W'(s.col);
    kd       = mirror ? (ADDR_W'(half_w) - ADDR_W'(1) - ADDR_W'(s.col[CNT_W-1:1]))
                      : ADDR_W'(s.col[CNT_W-1:1]);
    luma_sum = s.row_base + luma_col;
    // pair swap: first byte goes to odd slot, second to even
    semi_sum = s.row_base + {kd[ADDR_W-2:0], 1'b0} + ADDR_W'(!s.col[0]);
    prod     = PROD_W'(s.row) * PROD_W'(half_w);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      base_r       <= s.chroma ? semi_sum : luma_sum;
      prod_r       <= prod;
      kd_r         <= kd;
      use_planar_r <= s.chroma && planar;
      second_r     <= s.col[0];
    end
  end

  // second stage: U plane at ylen, V plane a quarter further on
  always_comb begin
    plane      = second_r ? ylen : (ylen + {2'b00, ylen[ADDR_W-1:2]});
    planar_sum = plane + ADDR_W'(prod_r) + kd_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      addr_r <= use_planar_r ? planar_sum : base_r;
    end
  end

  assign addr = addr_r;

endmodule

// ===== sv/nv21_chroma_reorder_mirror_unit.sv =====
// Top level of the NV21 chroma reorder / mirror unit.
// Depends on nv21rm_pkg, nv21rm_if, nv21rm_scan and nv21rm_addr.
//
//  channel | dir | payload                                  | handshake
//  --------+-----+------------------------------------------+-----------
//  in_ch   | in  | pixel_in[7:0]                            | valid/ready
//  out_ch  | out | dest_address[24:0] pixel_out frame_end   | valid/ready
//  cfg     | in  | cfg_index[1:0] cfg_data[12:0]            | cfg_we only
//
// One request per clock while out_ch is not stalled and no register write holds in_ch.ready low.
// Pipeline: scan snapshot register, mirror/product register, output register.
// A stall on out_ch freezes the whole pipe and drops in_ch.ready in the same cycle.
// in_ch.ready is low for one cycle after reset and after each register write,
// while the luma plane size product settles.
module nv21_chroma_reorder_mirror_unit import nv21rm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  nv21rm_in_if.sink            in_ch,
  nv21rm_out_if.source         out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data
);

  logic [DIM_W-1:0]  frame_width_r;
  logic [DIM_W-1:0]  frame_height_r;
  logic              planar_out_r;
  logic              mirror_enable_r;
  logic              cfg_hold_r;
  logic [ADDR_W-1:0] ylen_r;

  logic [DIM_W-1:0]  w_eff;
  logic [DIM_W-1:0]  h_eff;
  logic [2*DIM_W-1:0] ylen_nxt;

  logic  adv;
  logic  accept;
  scan_t cur;

  logic             v1_r, v2_r, vo_r;
  scan_t            s1_r;
  logic [PIX_W-1:0] pix1_r, pix2_r, pixo_r;
  logic             last2_r, lasto_r;
  logic [ADDR_W-1:0] addr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r   <= DIM_W'(640);
      frame_height_r  <= DIM_W'(480);
      planar_out_r    <= 1'b0;
      mirror_enable_r <= 1'b0;
      cfg_hold_r      <= 1'b1;
    end else begin
      cfg_hold_r <= cfg_we;
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_FRAME_WIDTH:   frame_width_r   <= cfg_data;
          REG_FRAME_HEIGHT:  frame_height_r  <= cfg_data;
          REG_PLANAR_OUT:    planar_out_r    <= cfg_data[0];
          REG_MIRROR_ENABLE: mirror_enable_r <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    w_eff    = eff_dim(frame_width_r, MAX_W_EVEN);
    h_eff    = eff_dim(frame_height_r, MAX_H_EVEN);
    ylen_nxt = (2*DIM_W)'(w_eff) * (2*DIM_W)'(h_eff);
  end

  always_ff @(posedge clk) begin
    ylen_r <= ylen_nxt[ADDR_W-1:0];
  end

  assign adv         = !vo_r || out_ch.ready;
  assign in_ch.ready = adv && !cfg_hold_r;
  assign accept      = in_ch.valid && in_ch.ready;

  nv21rm_scan u_scan (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .w      (w_eff),
    .h      (h_eff),
    .ylen   (ylen_r),
    .cur    (cur)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      vo_r <= 1'b0;
    end else if (adv) begin
      v1_r <= accept;
      v2_r <= v1_r;
      vo_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r    <= cur;
      pix1_r  <= in_ch.pixel_in;
      pix2_r  <= pix1_r;
      last2_r <= s1_r.last;
      pixo_r  <= pix2_r;
      lasto_r <= last2_r;
    end
  end

  nv21rm_addr u_addr (
    .clk    (clk),
    .en     (adv),
    .s      (s1_r),
    .w      (w_eff),
    .ylen   (ylen_r),
    .mirror (mirror_enable_r),
    .planar (planar_out_r),
    .addr   (addr)
  );

  assign out_ch.valid        = vo_r;
  assign out_ch.dest_address = addr;
  assign out_ch.pixel_out    = pixo_r;
  assign out_ch.frame_end    = lasto_r;

endmodule
